>>> design/mfhl_pkg.sv
// Shared constants, register codes and structs for the motor fault hypothesis latch.
// This package depends on nothing. Every design module imports it.
package mfhl_pkg;

  localparam int unsigned HYPOTHESES        = 7;
  localparam int unsigned HYP_BITS          = 3;
  localparam int unsigned MOTORS            = 6;
  localparam int unsigned MOTORS_PER_WORD   = 3;
  localparam int unsigned PWM_BITS_DEFAULT  = 11;
  localparam int unsigned COST_BITS_DEFAULT = 16;
  localparam int unsigned PWM_RESET         = 1000;
  localparam int unsigned STEP_LIMIT_BITS   = 11;
  localparam int unsigned FLOOR_BITS        = 16;
  localparam int unsigned MARGIN_BITS       = 4;
  localparam int unsigned COUNT_BITS        = 8;
  localparam int unsigned CFG_INDEX_BITS    = 3;
  localparam int unsigned CFG_DATA_BITS     = 16;

  localparam logic [MARGIN_BITS-1:0]     MARGIN_RESET     = 4'd6;
  localparam logic [FLOOR_BITS-1:0]      FLOOR_RESET      = 16'd128;
  localparam logic [COUNT_BITS-1:0]      LOCK_RESET       = 8'd15;
  localparam logic [STEP_LIMIT_BITS-1:0] STEP_LIMIT_RESET = 11'd5;
  localparam logic [COUNT_BITS-1:0]      WINDOW_RESET     = 8'd8;
  localparam logic [COUNT_BITS-1:0]      STREAK_MAX       = 8'd255;
  localparam logic [HYP_BITS-1:0]        HYP_HEALTHY      = 3'd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MARGIN     = 3'd0,
    CFG_FLOOR      = 3'd1,
    CFG_LOCK       = 3'd2,
    CFG_STEP_LIMIT = 3'd3,
    CFG_WINDOW_MIN = 3'd4
  } cfg_index_e;

  typedef enum logic {
    CMD_DECIDE = 1'b0,
    CMD_KILL   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [MARGIN_BITS-1:0]     margin_tenths;
    logic [FLOOR_BITS-1:0]      healthy_floor;
    logic [COUNT_BITS-1:0]      lock_length;
    logic [STEP_LIMIT_BITS-1:0] pwm_step_limit;
    logic [COUNT_BITS-1:0]      window_minimum;
  } cfg_t;

  typedef struct packed {
    logic [HYP_BITS-1:0] best;
    logic                fault;
  } sel_t;

  typedef struct packed {
    logic [HYP_BITS-1:0]   chosen;
    logic [HYP_BITS-1:0]   latched;
    logic [HYP_BITS-1:0]   candidate;
    logic [COUNT_BITS-1:0] streak;
    logic                  aggressive;
    logic                  fault;
  } result_t;

endpackage

>>> design/mfhl_select.sv
// Lowest-cost hypothesis search and fault qualification, purely combinational.
// Depends on mfhl_pkg.
module mfhl_select #(
  parameter int unsigned COST_BITS = mfhl_pkg::COST_BITS_DEFAULT
) (
  input  logic [mfhl_pkg::HYPOTHESES-1:0][COST_BITS-1:0] cost_i,
  input  logic [mfhl_pkg::COUNT_BITS-1:0]                window_count_i,
  input  mfhl_pkg::cfg_t                                 cfg_i,
  output mfhl_pkg::sel_t                                 sel_o
);
  import mfhl_pkg::*;

  localparam int unsigned PROD_BITS = COST_BITS + 4;
  localparam int unsigned CMP_BITS  = (COST_BITS > FLOOR_BITS) ? COST_BITS : FLOOR_BITS;

  logic [HYP_BITS-1:0]  best_idx;
  logic [COST_BITS-1:0] best_cost;
  logic [PROD_BITS-1:0] best_scaled;
  logic [PROD_BITS-1:0] healthy_scaled;
  logic                 window_full;
  logic                 above_floor;

  always_comb begin
    best_idx  = HYP_HEALTHY;
    best_cost = cost_i[0];
    for (int h = 1; h < HYPOTHESES; h++) begin
      if (cost_i[h] < best_cost) begin
        best_cost = cost_i[h];
        best_idx  = HYP_BITS'(h);
      end
    end
  end

  assign best_scaled    = PROD_BITS'(best_cost) * PROD_BITS'(10);
  assign healthy_scaled = PROD_BITS'(cost_i[0]) * PROD_BITS'(cfg_i.margin_tenths);
  assign window_full    = window_count_i >= cfg_i.window_minimum;
  assign above_floor    = CMP_BITS'(cost_i[0]) > CMP_BITS'(cfg_i.healthy_floor);

  assign sel_o.best  = best_idx;
  assign sel_o.fault = window_full && (best_idx != HYP_HEALTHY) && above_floor &&
                       (best_scaled < healthy_scaled);

endmodule

>>> design/mfhl_pwm.sv
// Previous PWM store and per-motor step detection against the step limit.
// Depends on mfhl_pkg.
module mfhl_pwm #(
  parameter int unsigned PWM_BITS = mfhl_pkg::PWM_BITS_DEFAULT
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           update_i,
  input  logic [mfhl_pkg::MOTORS_PER_WORD*PWM_BITS-1:0]  pwm_first_three_i,
  input  logic [mfhl_pkg::MOTORS_PER_WORD*PWM_BITS-1:0]  pwm_last_three_i,
  input  logic [mfhl_pkg::STEP_LIMIT_BITS-1:0]           step_limit_i,
  output logic                                           aggressive_o
);
  import mfhl_pkg::*;

  localparam int unsigned CMP_BITS =
    (PWM_BITS > STEP_LIMIT_BITS) ? PWM_BITS : STEP_LIMIT_BITS;

  logic [MOTORS-1:0][PWM_BITS-1:0] prev_q;
  logic [MOTORS-1:0][PWM_BITS-1:0] now;
  logic [MOTORS-1:0][PWM_BITS-1:0] step;
  logic [MOTORS-1:0]               over;

  always_comb begin
    for (int m = 0; m < MOTORS_PER_WORD; m++) begin
      now[m]                   = pwm_first_three_i[m*PWM_BITS +: PWM_BITS];
      now[m + MOTORS_PER_WORD] = pwm_last_three_i[m*PWM_BITS +: PWM_BITS];
    end
    for (int m = 0; m < MOTORS; m++) begin
      step[m] = (now[m] > prev_q[m]) ? (now[m] - prev_q[m]) : (prev_q[m] - now[m]);
      over[m] = CMP_BITS'(step[m]) > CMP_BITS'(step_limit_i);
    end
  end

  assign aggressive_o = |over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < MOTORS; m++) begin
        prev_q[m] <= PWM_BITS'(PWM_RESET);
      end
    end else if (update_i) begin
      prev_q <= now;
    end
  end

endmodule

>>> design/mfhl_latch.sv
// Candidate streak counting, lock latching and kill handling; builds the result.
// Depends on mfhl_pkg.
module mfhl_latch (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  logic                              kill_i,
  input  mfhl_pkg::sel_t                    sel_i,
  input  logic                              aggressive_i,
  input  logic [mfhl_pkg::COUNT_BITS-1:0]   lock_length_i,
  output mfhl_pkg::result_t                 result_o
);
  import mfhl_pkg::*;

  logic [HYP_BITS-1:0]   cand_q, cand_d;
  logic [COUNT_BITS-1:0] streak_q, streak_d;
  logic [HYP_BITS-1:0]   latched_q, latched_d;
  logic [HYP_BITS-1:0]   qualified;

  assign qualified = sel_i.fault ? sel_i.best : HYP_HEALTHY;

  always_comb begin
    cand_d    = cand_q;
    streak_d  = streak_q;
    latched_d = latched_q;
    result_o  = '0;
    if (kill_i) begin
      cand_d    = HYP_HEALTHY;
      streak_d  = '0;
      latched_d = HYP_HEALTHY;
    end else begin
      result_o.chosen = qualified;
      if (latched_q == HYP_HEALTHY) begin
        if (aggressive_i) begin
          streak_d = '0;
        end else if (qualified != HYP_HEALTHY) begin
          if (qualified == cand_q) begin
            if (streak_q != STREAK_MAX) begin
              streak_d = streak_q + COUNT_BITS'(1);
            end
          end else begin
            cand_d   = qualified;
            streak_d = COUNT_BITS'(1);
          end
          if (streak_d >= lock_length_i) begin
            latched_d = qualified;
          end
        end else begin
          streak_d = '0;
        end
      end else begin
        result_o.chosen = latched_q;
      end
      result_o.latched    = latched_d;
      result_o.candidate  = cand_d;
      result_o.streak     = streak_d;
      result_o.aggressive = aggressive_i;
      result_o.fault      = sel_i.fault;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q    <= HYP_HEALTHY;
      streak_q  <= '0;
      latched_q <= HYP_HEALTHY;
    end else if (advance_i) begin
      cand_q    <= cand_d;
      streak_q  <= streak_d;
      latched_q <= latched_d;
    end
  end

endmodule

>>> design/motor_fault_hypothesis_latch.sv
// Top level of the motor fault hypothesis latch: ports, config registers, item stages.
// Depends on mfhl_pkg, mfhl_select, mfhl_pwm and mfhl_latch.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_ready_o | cmd, seven costs, window, two PWM words
//   out     | output    | out_valid_o / out_ready_i | chosen, latched, candidate, streak, flags
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i is high; a taken item's result is set by
// the input register and then the result register, around the decide logic.
// Reset clears both stages, the streak state, the PWM history (1000 per motor) and
// loads the register defaults. A stalled result holds in the output register while
// one more item waits in the input register; in_ready_o drops only when both are full.
module motor_fault_hypothesis_latch #(
  parameter int unsigned PWM_BITS  = mfhl_pkg::PWM_BITS_DEFAULT,
  parameter int unsigned COST_BITS = mfhl_pkg::COST_BITS_DEFAULT
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic                                          cmd_i,
  input  logic [COST_BITS-1:0]                          cost_healthy_i,
  input  logic [COST_BITS-1:0]                          cost_one_i,
  input  logic [COST_BITS-1:0]                          cost_two_i,
  input  logic [COST_BITS-1:0]                          cost_three_i,
  input  logic [COST_BITS-1:0]                          cost_four_i,
  input  logic [COST_BITS-1:0]                          cost_five_i,
  input  logic [COST_BITS-1:0]                          cost_six_i,
  input  logic [mfhl_pkg::COUNT_BITS-1:0]               window_count_i,
  input  logic [mfhl_pkg::MOTORS_PER_WORD*PWM_BITS-1:0] pwm_first_three_i,
  input  logic [mfhl_pkg::MOTORS_PER_WORD*PWM_BITS-1:0] pwm_last_three_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [mfhl_pkg::HYP_BITS-1:0]                 chosen_hypothesis_o,
  output logic [mfhl_pkg::HYP_BITS-1:0]                 latched_hypothesis_o,
  output logic [mfhl_pkg::HYP_BITS-1:0]                 current_candidate_o,
  output logic [mfhl_pkg::COUNT_BITS-1:0]               streak_count_o,
  output logic                                          aggressive_flag_o,
  output logic                                          fault_raised_o,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [mfhl_pkg::CFG_INDEX_BITS-1:0]           cfg_index_i,
  input  logic [mfhl_pkg::CFG_DATA_BITS-1:0]            cfg_data_i
);
  import mfhl_pkg::*;

  localparam int unsigned WORD_BITS = MOTORS_PER_WORD * PWM_BITS;

  cfg_t cfg_q;

  logic                                 s1_valid_q;
  logic                                 cmd_q;
  logic [HYPOTHESES-1:0][COST_BITS-1:0] cost_q;
  logic [COUNT_BITS-1:0]                window_q;
  logic [WORD_BITS-1:0]                 pwm_first_q;
  logic [WORD_BITS-1:0]                 pwm_last_q;

  logic    out_valid_q;
  result_t res_q;
  result_t res;
  sel_t    sel;
  logic    aggressive;
  logic    advance;
  logic    kill;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign kill        = (cmd_e'(cmd_q) == CMD_KILL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin_tenths  <= MARGIN_RESET;
      cfg_q.healthy_floor  <= FLOOR_RESET;
      cfg_q.lock_length    <= LOCK_RESET;
      cfg_q.pwm_step_limit <= STEP_LIMIT_RESET;
      cfg_q.window_minimum <= WINDOW_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MARGIN:     cfg_q.margin_tenths  <= cfg_data_i[MARGIN_BITS-1:0];
        CFG_FLOOR:      cfg_q.healthy_floor  <= cfg_data_i[FLOOR_BITS-1:0];
        CFG_LOCK:       cfg_q.lock_length    <= cfg_data_i[COUNT_BITS-1:0];
        CFG_STEP_LIMIT: cfg_q.pwm_step_limit <= cfg_data_i[STEP_LIMIT_BITS-1:0];
        CFG_WINDOW_MIN: cfg_q.window_minimum <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q       <= cmd_i;
      cost_q[0]   <= cost_healthy_i;
      cost_q[1]   <= cost_one_i;
      cost_q[2]   <= cost_two_i;
      cost_q[3]   <= cost_three_i;
      cost_q[4]   <= cost_four_i;
      cost_q[5]   <= cost_five_i;
      cost_q[6]   <= cost_six_i;
      window_q    <= window_count_i;
      pwm_first_q <= pwm_first_three_i;
      pwm_last_q  <= pwm_last_three_i;
    end
  end

  mfhl_select #(
    .COST_BITS(COST_BITS)
  ) u_select (
    .cost_i        (cost_q),
    .window_count_i(window_q),
    .cfg_i         (cfg_q),
    .sel_o         (sel)
  );

  mfhl_pwm #(
    .PWM_BITS(PWM_BITS)
  ) u_pwm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .update_i         (advance && !kill),
    .pwm_first_three_i(pwm_first_q),
    .pwm_last_three_i (pwm_last_q),
    .step_limit_i     (cfg_q.pwm_step_limit),
    .aggressive_o     (aggressive)
  );

  mfhl_latch u_latch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .kill_i       (kill),
    .sel_i        (sel),
    .aggressive_i (aggressive),
    .lock_length_i(cfg_q.lock_length),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign chosen_hypothesis_o  = res_q.chosen;
  assign latched_hypothesis_o = res_q.latched;
  assign current_candidate_o  = res_q.candidate;
  assign streak_count_o       = res_q.streak;
  assign aggressive_flag_o    = res_q.aggressive;
  assign fault_raised_o       = res_q.fault;

endmodule

>>> design/mfhl_checker.sv
// Port-level checks on the result channel of the motor fault hypothesis latch.
// Depends on mfhl_pkg; bound to motor_fault_hypothesis_latch below.
module mfhl_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [mfhl_pkg::HYP_BITS-1:0]     chosen_hypothesis_o,
  input logic [mfhl_pkg::HYP_BITS-1:0]     latched_hypothesis_o,
  input logic [mfhl_pkg::HYP_BITS-1:0]     current_candidate_o,
  input logic [mfhl_pkg::COUNT_BITS-1:0]   streak_count_o,
  input logic                              aggressive_flag_o,
  input logic                              fault_raised_o
);
  import mfhl_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_hypothesis_o) &&
      $stable(latched_hypothesis_o) && $stable(streak_count_o))
    else $error("result changed while stalled");

  a_latched_chosen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && latched_hypothesis_o != HYP_HEALTHY |->
      chosen_hypothesis_o == latched_hypothesis_o)
    else $error("chosen differs from latched hypothesis");

  a_chosen_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && latched_hypothesis_o == HYP_HEALTHY &&
      chosen_hypothesis_o != HYP_HEALTHY |-> fault_raised_o)
    else $error("unlatched choice without fault");

  a_streak_candidate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && latched_hypothesis_o == HYP_HEALTHY && streak_count_o != '0 |->
      current_candidate_o != HYP_HEALTHY)
    else $error("streak without candidate");

  a_aggressive_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && aggressive_flag_o && latched_hypothesis_o == HYP_HEALTHY |->
      streak_count_o == '0)
    else $error("aggressive step kept streak");

endmodule

bind motor_fault_hypothesis_latch mfhl_checker u_mfhl_checker (.*);
